@@ hdl/ped_pkg.sv @@
// Shared types, constants and helpers for the percent-escape decoder.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package ped_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;
  localparam logic [ByteW-1:0] PctChar   = 8'h25;
  localparam logic [3:0]       DigitBase = 4'd10;

  // Escape phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_e;

  // One raw input beat
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } item_t;

  // Results of one input beat: data[0] goes out first
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] data;
    logic [CntW-1:0]              cnt;
    logic                         last;
  } grp_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_nib(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h41) + DigitBase};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h61) + DigitBase};
    end
    return r;
  endfunction

endpackage

@@ hdl/ped_in_skid.sv @@
// Input register with a skid entry; ready is a register output.
// Depends on ped_pkg.
`timescale 1ns / 1ps

module ped_in_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_vld_i,
  output logic           s_rdy_o,
  input  ped_pkg::item_t s_item_i,
  output logic           m_vld_o,
  input  logic           m_take_i,
  output ped_pkg::item_t m_item_o
);

  logic           main_vld_q, main_vld_d;
  logic           skid_vld_q, skid_vld_d;
  ped_pkg::item_t main_q, main_d;
  ped_pkg::item_t skid_q, skid_d;
  logic           acc;

  assign s_rdy_o  = ~skid_vld_q;
  assign acc      = s_vld_i & s_rdy_o;
  assign m_vld_o  = main_vld_q;
  assign m_item_o = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || m_take_i) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else if (acc) begin
        main_d     = s_item_i;
        main_vld_d = 1'b1;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (acc) begin
      skid_d     = s_item_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

@@ hdl/ped_core.sv @@
// Escape decode: phase machine, held digit, and the result group per beat.
// Depends on ped_pkg.
`timescale 1ns / 1ps

module ped_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  ped_pkg::item_t item_i,
  input  logic           load_ok_i,
  output logic           take_o,
  output ped_pkg::grp_t  grp_o
);

  ped_pkg::phase_e          phase_q, phase_d;
  logic [ped_pkg::ByteW-1:0] held_q, held_d;
  logic [4:0]               cur_hx;
  logic [4:0]               held_hx;
  logic                     is_hex;
  logic                     is_pct;
  logic [ped_pkg::ByteW-1:0] dec;

  assign take_o  = vld_i & load_ok_i;
  assign cur_hx  = ped_pkg::hex_nib(item_i.data);
  assign held_hx = ped_pkg::hex_nib(held_q);
  assign is_hex  = cur_hx[4];
  assign is_pct  = (item_i.data == ped_pkg::PctChar);
  assign dec     = {held_hx[3:0], cur_hx[3:0]};

  always_comb begin
    phase_d      = phase_q;
    held_d       = held_q;
    grp_o.data   = {ped_pkg::MaxRes{item_i.data}};
    grp_o.cnt    = 2'd0;
    grp_o.last   = item_i.last;
    unique case (phase_q)
      ped_pkg::PH_PCT: begin
        if (item_i.last) begin
          grp_o.data[0] = ped_pkg::PctChar;
          grp_o.cnt     = 2'd2;
          phase_d       = ped_pkg::PH_IDLE;
        end else if (is_hex) begin
          held_d  = item_i.data;
          phase_d = ped_pkg::PH_DIG;
        end else begin
          grp_o.data[0] = ped_pkg::PctChar;
          if (is_pct) begin
            grp_o.cnt = 2'd1;
            phase_d   = ped_pkg::PH_PCT;
          end else begin
            grp_o.cnt = 2'd2;
            phase_d   = ped_pkg::PH_IDLE;
          end
        end
      end
      ped_pkg::PH_DIG: begin
        if (is_hex) begin
          grp_o.data[0] = dec;
          grp_o.cnt     = 2'd1;
          phase_d       = ped_pkg::PH_IDLE;
        end else begin
          grp_o.data[0] = ped_pkg::PctChar;
          grp_o.data[1] = held_q;
          // a fresh '%' restarts the escape unless the string ends here
          if (is_pct && !item_i.last) begin
            grp_o.cnt = 2'd2;
            phase_d   = ped_pkg::PH_PCT;
          end else begin
            grp_o.cnt = 2'd3;
            phase_d   = ped_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        if (is_pct && !item_i.last) begin
          phase_d = ped_pkg::PH_PCT;
        end else begin
          grp_o.cnt = 2'd1;
          phase_d   = ped_pkg::PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ped_pkg::PH_IDLE;
    end else if (take_o) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      held_q <= held_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |=> phase_q == ped_pkg::PH_IDLE)
    else $error("phase not cleared after string end");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last |-> grp_o.cnt != 2'd0)
    else $error("string end with no result");

  a_three_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && grp_o.cnt == 2'd3 |=> phase_q == ped_pkg::PH_IDLE)
    else $error("three-byte flush left an escape pending");

  a_idle_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && phase_q == ped_pkg::PH_IDLE |-> grp_o.cnt == 2'd0 || grp_o.cnt == 2'd1)
    else $error("idle phase gave more than one byte");

endmodule

@@ hdl/ped_out_buf.sv @@
// Result register: holds one group of up to three bytes and sends one per beat.
// Depends on ped_pkg.
`timescale 1ns / 1ps

module ped_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  ped_pkg::grp_t             grp_i,
  output logic                      load_ok_o,
  output logic                      m_vld_o,
  input  logic                      m_rdy_i,
  output logic [ped_pkg::ByteW-1:0] m_data_o,
  output logic                      m_last_o
);

  logic [ped_pkg::MaxRes-1:0][ped_pkg::ByteW-1:0] byte_q, byte_d;
  logic [ped_pkg::MaxRes-1:0]                     last_q, last_d;
  logic [ped_pkg::CntW-1:0]                       cnt_q, cnt_d;
  logic                                           pop;

  assign m_vld_o   = (cnt_q != 2'd0);
  assign m_data_o  = byte_q[0];
  assign m_last_o  = last_q[0];
  assign pop       = m_vld_o & m_rdy_i;
  assign load_ok_o = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & pop);

  always_comb begin
    byte_d = byte_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      byte_d = grp_i.data;
      cnt_d  = grp_i.cnt;
      for (int i = 0; i < ped_pkg::MaxRes; i++) begin
        last_d[i] = grp_i.last && (grp_i.cnt == ped_pkg::CntW'(i + 1));
      end
    end else if (pop) begin
      byte_d = {byte_q[ped_pkg::MaxRes-1], byte_q[ped_pkg::MaxRes-1:1]};
      last_d = {1'b0, last_q[ped_pkg::MaxRes-1:1]};
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_o && m_last_o |-> cnt_q == 2'd1)
    else $error("last flag on a byte that is not the final one");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && grp_i.cnt != 2'd0 |=> cnt_q == $past(grp_i.cnt))
    else $error("result group lost on load");

endmodule

@@ hdl/percent_escape_decoder_unit.sv @@
// Top level of the streaming percent-escape decoder.
// Depends on ped_pkg, ped_in_skid, ped_core, ped_out_buf.
`timescale 1ns / 1ps
//
//  port group      dir   tdata           tlast
//  s_axis_*        in    [7:0] in_byte   in_last
//  m_axis_*        out   [7:0] out_byte  out_last
//
//  One input beat per cycle while the output is ready; a beat yielding one byte
//  passes the input register and the result register. A beat yielding two or three
//  bytes holds the input side while the result register drains one byte per cycle.
//  s_axis_tready is a register output (skid entry), so output stalls lower it in the
//  cycle after they hold the core. Reset: phase idle, all buffers empty.

module percent_escape_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  ped_pkg::item_t s_item;
  ped_pkg::item_t core_item;
  ped_pkg::grp_t  grp;
  logic           core_vld;
  logic           take;
  logic           load_ok;

  assign s_item.data = s_axis_tdata;
  assign s_item.last = s_axis_tlast;

  ped_in_skid u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_vld_i  (s_axis_tvalid),
    .s_rdy_o  (s_axis_tready),
    .s_item_i (s_item),
    .m_vld_o  (core_vld),
    .m_take_i (take),
    .m_item_o (core_item)
  );

  ped_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (core_vld),
    .item_i    (core_item),
    .load_ok_i (load_ok),
    .take_o    (take),
    .grp_o     (grp)
  );

  ped_out_buf u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (take),
    .grp_i     (grp),
    .load_ok_o (load_ok),
    .m_vld_o   (m_axis_tvalid),
    .m_rdy_i   (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule
